[hdl/audio_activity_fade_gate_top_defines.svh]
// Assertion macros used by the checker file of the fade gate.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef AUDIO_ACTIVITY_FADE_GATE_TOP_DEFINES_SVH
`define AUDIO_ACTIVITY_FADE_GATE_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define AFG_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fade gate check failed");

// A consequence that must hold in the cycle after its antecedent.
`define AFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fade gate check failed");

`endif

[hdl/afg_pkg.sv]
package afg_pkg;

  localparam int unsigned STEP_W = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned DEN_W = 20;
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned PROD_W = DEN_W + QUOT_W;

  localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TIME = 2'd3;

  localparam logic [15:0] Q_ONE = 16'd32768;

  localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LOUD = 4'd1;
  localparam logic [STEP_W-1:0] STEP_QUIET = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CALC = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CHECK = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DIV = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DWAIT = 4'd7;
  localparam logic [STEP_W-1:0] STEP_PROG = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FINISH = 4'd9;
  localparam logic [STEP_W-1:0] STEP_EMIT = 4'd10;
  localparam logic [STEP_W-1:0] STEP_RET = 4'd11;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] audio_level;
    logic        audio_ready;
  } upd_item_t;

  typedef struct packed {
    logic [15:0] fade_progress;
    logic        audio_active;
    logic        fade_running;
    logic        fading_in;
  } res_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_LOUD,
    OP_QUIET,
    OP_CALC,
    OP_MUL,
    OP_DIV_GO,
    OP_PROG,
    OP_FINISH,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_NO_ITEM,
    JMP_SKIP,
    JMP_NOT_FADING,
    JMP_DONE,
    JMP_DIV_BUSY,
    JMP_OUT_BUSY,
    JMP_ALWAYS
  } jcond_t;

  typedef struct packed {
    uop_t              op;
    jcond_t            cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic item_valid;
    logic skip;
    logic not_fading;
    logic done;
    logic out_busy;
  } dp_status_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      STEP_WAIT:   w = '{OP_TAKE,   JMP_NO_ITEM,    STEP_WAIT};
      STEP_LOUD:   w = '{OP_LOUD,   JMP_SKIP,       STEP_EMIT};
      STEP_QUIET:  w = '{OP_QUIET,  JMP_NOT_FADING, STEP_EMIT};
      STEP_CALC:   w = '{OP_CALC,   JMP_NEVER,      STEP_WAIT};
      STEP_CHECK:  w = '{OP_NOP,    JMP_DONE,       STEP_FINISH};
      STEP_MUL:    w = '{OP_MUL,    JMP_NEVER,      STEP_WAIT};
      STEP_DIV:    w = '{OP_DIV_GO, JMP_NEVER,      STEP_WAIT};
      STEP_DWAIT:  w = '{OP_NOP,    JMP_DIV_BUSY,   STEP_DWAIT};
      STEP_PROG:   w = '{OP_PROG,   JMP_ALWAYS,     STEP_EMIT};
      STEP_FINISH: w = '{OP_FINISH, JMP_NEVER,      STEP_WAIT};
      STEP_EMIT:   w = '{OP_EMIT,   JMP_OUT_BUSY,   STEP_EMIT};
      STEP_RET:    w = '{OP_NOP,    JMP_ALWAYS,     STEP_WAIT};
      default:     w = '{OP_NOP,    JMP_ALWAYS,     STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

[hdl/audio_activity_fade_gate_top.sv]
// Noise gate with linear attack and release fades, stepped once per update tick.
// Update channel: upd_valid, upd_stall, upd_item (time, level, audio ready). An item
// is taken only when the control program sits at its wait step; upd_stall is high
// at all other times.
// Result channel: res_valid, res_stall, res_item. One result per update, held in an
// output register; while res_stall is high the result and res_valid stay put and
// the program waits at its emit step before it takes the next update.
// Configuration channel: cfg_valid, cfg_ready (always high), cfg_index, cfg_data.
// The user must write registers only while no update is in flight; the block does not enforce it.
// Steps per update: wait, loud, emit, return when the gate is off or audio is not ready;
// else wait, loud, quiet, then emit, return when no fade runs; calc, check, finish before
// emit when a fade completes; calc, check, mul, div, a wait on the 16-step serial divider
// that scales the elapsed time over the fade length, and prog when a fade advances.
// Synchronous reset restores the register defaults, clears all gate state and
// returns the program to its wait step with no result pending.
module audio_activity_fade_gate_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            upd_valid,
  output logic                            upd_stall,
  input  afg_pkg::upd_item_t              upd_item,
  output logic                            res_valid,
  input  logic                            res_stall,
  output afg_pkg::res_item_t              res_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [afg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  afg_pkg::uword_t            uw;
  afg_pkg::dp_status_t        status;
  logic                       div_busy;
  logic                       div_start;
  logic [afg_pkg::PROD_W-1:0] div_num;
  logic [afg_pkg::DEN_W-1:0]  div_den;
  logic [afg_pkg::QUOT_W-1:0] div_q;

  assign upd_stall = uw.op != afg_pkg::OP_TAKE;
  assign cfg_ready = 1'b1;

  afg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .div_busy (div_busy),
    .uw       (uw)
  );

  afg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_q)
  );

  afg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (uw.op),
    .upd_valid (upd_valid),
    .upd_item  (upd_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .div_q     (div_q),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

[hdl/afg_div.sv]
module afg_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [afg_pkg::PROD_W-1:0]       num,
  input  logic [afg_pkg::DEN_W-1:0]        den,
  output logic                             busy,
  output logic [afg_pkg::QUOT_W-1:0]       quot
);

  localparam int unsigned CNT_W = $clog2(afg_pkg::QUOT_W + 1);
  localparam int unsigned DW = afg_pkg::DEN_W;
  localparam int unsigned QW = afg_pkg::QUOT_W;

  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] count;
  logic [DW:0]      shifted;
  logic [DW:0]      trial;
  logic             fits;

  assign shifted = {rem, quot[QW-1]};
  assign trial = shifted - {1'b0, den_r};
  assign fits = shifted >= {1'b0, den_r};
  assign busy = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      rem   <= num[afg_pkg::PROD_W-1:QW];
      quot  <= num[QW-1:0];
      den_r <= den;
      count <= CNT_W'(QW);
    end else if (busy) begin
      rem   <= fits ? trial[DW-1:0] : shifted[DW-1:0];
      quot  <= {quot[QW-2:0], fits};
      count <= count - 1'b1;
    end
  end

endmodule

[hdl/afg_seq.sv]
module afg_seq (
  input  logic                clk,
  input  logic                rst,
  input  afg_pkg::dp_status_t status,
  input  logic                div_busy,
  output afg_pkg::uword_t     uw
);

  logic [afg_pkg::STEP_W-1:0] step;
  logic [afg_pkg::STEP_W-1:0] step_next;
  logic                       jump;

  assign uw = afg_pkg::ucode(step);

  always_comb begin
    unique case (uw.cond)
      afg_pkg::JMP_NEVER:      jump = 1'b0;
      afg_pkg::JMP_NO_ITEM:    jump = !status.item_valid;
      afg_pkg::JMP_SKIP:       jump = status.skip;
      afg_pkg::JMP_NOT_FADING: jump = status.not_fading;
      afg_pkg::JMP_DONE:       jump = status.done;
      afg_pkg::JMP_DIV_BUSY:   jump = div_busy;
      afg_pkg::JMP_OUT_BUSY:   jump = status.out_busy;
      afg_pkg::JMP_ALWAYS:     jump = 1'b1;
      default:                 jump = 1'b0;
    endcase
  end

  assign step_next = jump ? uw.target : step + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= afg_pkg::STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

[hdl/afg_dp.sv]
module afg_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  afg_pkg::uop_t                       op,
  input  logic                                upd_valid,
  input  afg_pkg::upd_item_t                  upd_item,
  input  logic                                cfg_valid,
  input  logic [afg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [afg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [afg_pkg::QUOT_W-1:0]          div_q,
  output logic                                div_start,
  output logic [afg_pkg::PROD_W-1:0]          div_num,
  output logic [afg_pkg::DEN_W-1:0]           div_den,
  output afg_pkg::dp_status_t                 status,
  output logic                                res_valid,
  input  logic                                res_stall,
  output afg_pkg::res_item_t                  res_item
);

  logic        gate_enable;
  logic [15:0] level_threshold;
  logic [19:0] release_timeout_ms;
  logic [15:0] attack_time_ms;

  logic        active;
  logic        fading;
  logic        direction;
  logic [15:0] progress;
  logic [15:0] start_progress;
  logic [31:0] fade_start_time;
  logic [31:0] last_loud_time;

  afg_pkg::upd_item_t item;
  logic [31:0] elapsed;
  logic [19:0] dur;
  logic [afg_pkg::PROD_W-1:0] product;

  logic        loud;
  logic [31:0] quiet_gap;
  logic        quiet_begin;
  logic [15:0] mul_a;
  logic [19:0] mul_b;
  logic        out_busy;

  assign loud = item.audio_level > level_threshold;
  assign quiet_gap = item.now_ms - last_loud_time;
  assign quiet_begin = active && (quiet_gap > {12'd0, release_timeout_ms})
                       && (!fading || direction);
  assign mul_a = direction ? (afg_pkg::Q_ONE - start_progress) : start_progress;
  assign mul_b = direction ? elapsed[19:0] : (dur - elapsed[19:0]);
  assign out_busy = res_valid && res_stall;

  assign status.item_valid = upd_valid;
  assign status.skip = !gate_enable || !item.audio_ready;
  assign status.not_fading = !(fading || quiet_begin);
  assign status.done = (dur == '0) || (elapsed >= {12'd0, dur});
  assign status.out_busy = out_busy;

  assign div_start = op == afg_pkg::OP_DIV_GO;
  assign div_num = product;
  assign div_den = dur;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_enable        <= 1'b0;
      level_threshold    <= 16'd32768;
      release_timeout_ms <= 20'd5000;
      attack_time_ms     <= 16'd500;
    end else if (cfg_valid) begin
      case (cfg_index)
        afg_pkg::REG_GATE_ENABLE:     gate_enable <= cfg_data[0];
        afg_pkg::REG_LEVEL_THRESHOLD: level_threshold <= cfg_data[15:0];
        afg_pkg::REG_RELEASE_TIMEOUT: release_timeout_ms <= cfg_data;
        afg_pkg::REG_ATTACK_TIME:     attack_time_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      fading          <= 1'b0;
      direction       <= 1'b0;
      progress        <= '0;
      start_progress  <= '0;
      fade_start_time <= '0;
      last_loud_time  <= '0;
    end else begin
      case (op)
        afg_pkg::OP_TAKE: begin
          if (upd_valid) begin
            item <= upd_item;
          end
        end
        afg_pkg::OP_LOUD: begin
          if (!gate_enable) begin
            active   <= 1'b0;
            fading   <= 1'b0;
            progress <= '0;
          end else if (item.audio_ready && loud) begin
            last_loud_time <= item.now_ms;
            if (!active || (fading && !direction)) begin
              active          <= 1'b1;
              fading          <= 1'b1;
              direction       <= 1'b1;
              start_progress  <= progress;
              fade_start_time <= item.now_ms;
            end
          end
        end
        afg_pkg::OP_QUIET: begin
          if (quiet_begin) begin
            fading          <= 1'b1;
            direction       <= 1'b0;
            start_progress  <= progress;
            fade_start_time <= item.now_ms;
          end
        end
        afg_pkg::OP_CALC: begin
          elapsed <= item.now_ms - fade_start_time;
          dur     <= direction ? {4'd0, attack_time_ms} : release_timeout_ms;
        end
        afg_pkg::OP_MUL: begin
          product <= afg_pkg::PROD_W'(mul_a) * afg_pkg::PROD_W'(mul_b);
        end
        afg_pkg::OP_PROG: begin
          progress <= direction ? (start_progress + div_q) : div_q;
        end
        afg_pkg::OP_FINISH: begin
          fading <= 1'b0;
          if (direction) begin
            progress <= afg_pkg::Q_ONE;
          end else begin
            progress <= '0;
            active   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (op == afg_pkg::OP_EMIT && !out_busy) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == afg_pkg::OP_EMIT && !out_busy) begin
      res_item.fade_progress <= progress;
      res_item.audio_active  <= active;
      res_item.fade_running  <= fading;
      res_item.fading_in     <= direction;
    end
  end

endmodule

[hdl/afg_checker.sv]
`include "audio_activity_fade_gate_top_defines.svh"

module afg_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input afg_pkg::res_item_t res_item
);

  logic idle_ok;
  logic settled_ok;

  assign idle_ok = res_item.audio_active || res_item.fade_progress == 16'd0;
  assign settled_ok = !res_item.audio_active || res_item.fade_running
                      || res_item.fade_progress == 16'd32768;

  `AFG_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
  `AFG_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res_item))
  `AFG_ASSERT_NOW(a_progress_max, !res_valid || res_item.fade_progress <= 16'd32768)
  `AFG_ASSERT_NOW(a_idle_zero, !res_valid || idle_ok)
  `AFG_ASSERT_NOW(a_settled_full, !res_valid || settled_ok)

endmodule

bind audio_activity_fade_gate_top afg_checker u_afg_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);
